### rtl/pe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pe_pkg: shared types and constants of the polynomial evaluator
// Field widths, function codes, register address, sequencer states and the
// multiply-add unit's control and status groups.
// ----------------------------------------------------------------------------
package pe_pkg;

	localparam int COEF_W = 16;	// signed Q8.8
	localparam int X_W    = 16;	// signed Q8.8
	localparam int ACC_W  = 32;	// signed Q16.16
	localparam int IDX_W  = 4;	// coef_index field
	localparam int DEG_W  = 4;	// degree register
	localparam int PROD_W = ACC_W + X_W;

	localparam logic [1:0] ADDR_DEGREE = 2'd0;	// degree register, byte address 0

	typedef enum logic {
		FUNC_WRITE = 1'b0,
		FUNC_EVAL  = 1'b1
	} func_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_ADD  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	// control into the shared multiply-add unit
	typedef struct packed {
		logic mul_en;
	} mac_ctrl_t;

	// status out of the shared multiply-add unit
	typedef struct packed {
		logic signed [ACC_W-1:0] value;
		logic                    ovf;
	} mac_res_t;

endpackage

### rtl/pe_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pe_if: request and result channels of the polynomial evaluator
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface pe_in_if;
	logic                            valid;
	logic                            ready;
	logic                            func;
	logic [pe_pkg::IDX_W-1:0]        coef_index;
	logic signed [pe_pkg::COEF_W-1:0] coef_value;
	logic signed [pe_pkg::X_W-1:0]    x_value;

	modport source (output valid, func, coef_index, coef_value, x_value, input ready);
	modport sink   (input valid, func, coef_index, coef_value, x_value, output ready);
endinterface

interface pe_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [pe_pkg::ACC_W-1:0]  poly_value;
	logic                             overflow;

	modport source (output valid, poly_value, overflow, input ready);
	modport sink   (input valid, poly_value, overflow, output ready);
endinterface

### rtl/polynomial_evaluator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_evaluator: Horner evaluation of a stored fixed-point polynomial
// Sequence: a coefficient write is stored at its transfer; an evaluation of degree
//   d runs d Horner steps, each a multiply state and an add state, then FIN.
// Flow: writes go back to back while idle; an evaluation holds ready low until its
//   d steps on the single shared multiply-add unit are done, and longer while the
//   previous result still waits in the output register.
// Reset: arst_n asynchronous; degree to 1, coefficient table to zero.
// ----------------------------------------------------------------------------
module polynomial_evaluator #(
	parameter int MAX_DEGREE = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	pe_in_if.sink       req,
	pe_out_if.source    rsp,
	// APB-style configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import pe_pkg::*;

	localparam int DEPTH = MAX_DEGREE + 1;
	localparam int SEL_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// coefficient table: small, read at the step counter and the clamped degree, so flops
	logic signed [COEF_W-1:0] coef_q [DEPTH];
	logic [DEG_W-1:0]         degree_q;

	state_t                   state_q;
	logic [SEL_W-1:0]         step_q;	// coefficient index of the next add
	logic signed [X_W-1:0]    x_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     ovf_q;

	// output register, decouples result hand-off from the sequencer
	logic                     out_valid_q;
	logic signed [ACC_W-1:0]  poly_q;
	logic                     out_ovf_q;

	logic                     in_xfer, eval_xfer, wr_xfer, out_free;
	logic [31:0]              deg_w, wr_idx_w;
	logic [SEL_W-1:0]         d_clamp;
	logic                     wr_in_range;
	mac_ctrl_t                mac_ctrl;
	mac_res_t                 mac_res;

	// ---- configuration port ------------------------------------------------
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_DEGREE) ? 32'(degree_q) : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= DEG_W'(1);
		end else if (psel && penable && pwrite && pready && paddr == ADDR_DEGREE) begin
			degree_q <= pwdata[DEG_W-1:0];
		end
	end

	// ---- request decode ----------------------------------------------------
	assign req.ready = (state_q == ST_IDLE);
	assign in_xfer   = req.valid && req.ready;
	assign eval_xfer = in_xfer && (func_t'(req.func) == FUNC_EVAL);
	assign wr_xfer   = in_xfer && (func_t'(req.func) == FUNC_WRITE);

	// degree 0 runs as 1, anything above the table runs as the top entry
	assign deg_w = 32'(degree_q);
	always_comb begin
		if (deg_w == 32'd0) begin
			d_clamp = SEL_W'(1);
		end else if (deg_w > 32'(MAX_DEGREE)) begin
			d_clamp = SEL_W'(MAX_DEGREE);
		end else begin
			d_clamp = SEL_W'(deg_w);
		end
	end

	// writes past the table are dropped
	assign wr_idx_w    = 32'(req.coef_index);
	assign wr_in_range = (wr_idx_w <= 32'(MAX_DEGREE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				coef_q[i] <= '0;
			end
		end else if (wr_xfer && wr_in_range) begin
			coef_q[SEL_W'(wr_idx_w)] <= req.coef_value;
		end
	end

	// ---- sequencer ---------------------------------------------------------
	// IDLE -> (MUL -> ADD) x d -> FIN -> IDLE; FIN waits for the output slot
	assign out_free      = !out_valid_q || rsp.ready;
	assign mac_ctrl.mul_en = (state_q == ST_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (eval_xfer) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					state_q <= (step_q == '0) ? ST_FIN : ST_MUL;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers: leading coefficient seeds the accumulator
	always_ff @(posedge clk) begin
		if (eval_xfer) begin
			x_q    <= req.x_value;
			acc_q  <= {{(ACC_W-COEF_W-8){coef_q[d_clamp][COEF_W-1]}}, coef_q[d_clamp], 8'h00};
			step_q <= d_clamp - SEL_W'(1);
			ovf_q  <= 1'b0;
		end else if (state_q == ST_ADD) begin
			acc_q <= mac_res.value;
			ovf_q <= ovf_q || mac_res.ovf;
			if (step_q != '0) begin
				step_q <= step_q - SEL_W'(1);
			end
		end
	end

	pe_mac_unit u_mac (
		.clk  (clk),
		.ctrl (mac_ctrl),
		.acc  (acc_q),
		.x    (x_q),
		.coef (coef_q[step_q]),
		.res  (mac_res)
	);

	// ---- result register ---------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			poly_q    <= acc_q;
			out_ovf_q <= ovf_q;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.poly_value = poly_q;
	assign rsp.overflow   = out_ovf_q;

	// ---- assertions --------------------------------------------------------
`ifndef ASSERT_OFF
	a_eval_starts: assert property (@(posedge clk) disable iff (!arst_n)
		eval_xfer |=> state_q == ST_MUL)
		else $error("evaluation transfer did not start the multiply step");

	a_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD && step_q == '0) |=> state_q == ST_FIN)
		else $error("last Horner step did not finish the evaluation");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_free) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("finished result not presented");

	a_step_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> 32'(step_q) < 32'(MAX_DEGREE))
		else $error("step counter outside coefficient table");
`endif

endmodule

### rtl/pe_mac_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pe_mac_unit: shared Horner step
// Registered acc*x product, then round to Q16.16, saturate, add the
// coefficient and saturate again.
// ----------------------------------------------------------------------------
module pe_mac_unit (
	input  logic                             clk,
	input  pe_pkg::mac_ctrl_t                ctrl,
	input  logic signed [pe_pkg::ACC_W-1:0]  acc,
	input  logic signed [pe_pkg::X_W-1:0]    x,
	input  logic signed [pe_pkg::COEF_W-1:0] coef,
	output pe_pkg::mac_res_t                 res
);
	import pe_pkg::*;

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [PROD_W:0]   rnd;
	logic [PROD_W-8:0]        sh;	// rnd >>> 8
	logic                     p_pos, p_neg;
	logic signed [ACC_W-1:0]  p_sat;
	logic signed [ACC_W:0]    sum;
	logic signed [ACC_W:0]    coef_q16;

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_s1 <= PROD_W'(acc) * PROD_W'(x);
		end
	end

	// round half up: add half an LSB of Q16.16, floor by arithmetic shift
	assign rnd   = {prod_s1[PROD_W-1], prod_s1} + (PROD_W+1)'(128);
	assign sh    = rnd[PROD_W:8];
	assign p_pos = !sh[PROD_W-8] && (sh[PROD_W-9:ACC_W-1] != '0);
	assign p_neg =  sh[PROD_W-8] && (sh[PROD_W-9:ACC_W-1] != '1);

	always_comb begin
		if (p_pos) begin
			p_sat = {1'b0, {(ACC_W-1){1'b1}}};
		end else if (p_neg) begin
			p_sat = {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			p_sat = sh[ACC_W-1:0];
		end
	end

	assign coef_q16 = {{(ACC_W+1-COEF_W-8){coef[COEF_W-1]}}, coef, 8'h00};
	assign sum      = {p_sat[ACC_W-1], p_sat} + coef_q16;

	always_comb begin
		res.ovf = p_pos || p_neg;
		if (sum[ACC_W] != sum[ACC_W-1]) begin
			res.ovf   = 1'b1;
			res.value = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			res.value = sum[ACC_W-1:0];
		end
	end

endmodule
